// ===== hdl/kvt_pkg.sv =====
`default_nettype none

package kvt_pkg;

    localparam int KEY_W       = 32;
    localparam int VALUE_W     = 32;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int SLOT_W      = 4;
    localparam int OCC_W       = 5;
    localparam int NUM_SLOTS_D = 16;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_GET    = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } entry_t;

endpackage

`default_nettype wire

// ===== hdl/key_value_table_linear_search_top.sv =====
`default_nettype none
// Key-value table with linear search over NUM_SLOTS slots.
// Request channel (s_*): s_tuser carries the request code (add, remove, get),
// s_tdata the key and the value word. A beat is taken when s_tvalid and
// s_tready are both high. Result channel (m_*): m_tuser carries the status,
// m_tdata the value found, the slot index and the occupied count.
// Every request gives exactly one result beat.
// One request at a time: a request is accepted in the idle cycle, then the
// slot memory is read one entry per cycle through the registered memory
// port, then the done state writes back and loads the result register.
// The next request is accepted only after the result register is loaded.
// After reset a clearing pass writes every slot empty, and s_tready stays
// low during it.
// A stalled result stays in the output register; the next request is still
// accepted and scanned, and its result waits until the register is free.
module key_value_table_linear_search_top #(
    parameter int NUM_SLOTS = kvt_pkg::NUM_SLOTS_D
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] key, [63:32] value
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [31:0] value_out, [35:32] slot,
                                        // [40:36] occupied, [47:41] zero
    output logic [1:0]       m_tuser    // [1:0] status
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    // slot memory
    kvt_pkg::entry_t mem [NUM_SLOTS];
    kvt_pkg::entry_t rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    kvt_pkg::entry_t  mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // control
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              found_reg, found_next;
    logic              free_found_reg, free_found_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // payload
    logic [kvt_pkg::REQ_W-1:0]   req_reg, req_next;
    logic [kvt_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [kvt_pkg::VALUE_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0]            hit_idx_reg, hit_idx_next;
    logic [kvt_pkg::VALUE_W-1:0] hit_val_reg, hit_val_next;
    logic [IDX_W-1:0]            free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]            cmp_idx_reg, cmp_idx_next;
    logic [kvt_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [kvt_pkg::VALUE_W-1:0] out_value_reg, out_value_next;
    logic [kvt_pkg::SLOT_W-1:0]  out_slot_reg, out_slot_next;
    logic [kvt_pkg::OCC_W-1:0]   out_occ_reg, out_occ_next;

    // result of the finished scan
    logic [kvt_pkg::STATUS_W-1:0] res_status;
    logic [kvt_pkg::VALUE_W-1:0]  res_value;
    logic [IDX_W-1:0]             res_idx;
    logic                         res_we;
    kvt_pkg::entry_t              res_wdata;
    logic [CNT_W-1:0]             res_count;
    logic [31:0]                  res_idx_ext;
    logic [31:0]                  res_count_ext;

    logic in_accept;
    logic out_free;
    logic out_load;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = (state_reg == S_DONE) && out_free;
    assign rd_addr   = cnt_reg[IDX_W-1:0];

    always_comb
    begin
        res_status = kvt_pkg::ST_NOT_FOUND;
        res_value  = '0;
        res_idx    = '0;
        res_we     = 1'b0;
        res_wdata  = '0;
        res_count  = count_reg;
        case (req_reg)
            kvt_pkg::REQ_ADD:
            begin
                if (found_reg)
                begin
                    res_status = kvt_pkg::ST_PRESENT;
                    res_idx    = hit_idx_reg;
                end
                else if (free_found_reg)
                begin
                    res_status      = kvt_pkg::ST_OK;
                    res_idx         = free_idx_reg;
                    res_we          = 1'b1;
                    res_wdata.valid = 1'b1;
                    res_wdata.key   = key_reg;
                    res_wdata.value = val_reg;
                    res_count       = count_reg + CNT_W'(1);
                end
                else
                begin
                    res_status = kvt_pkg::ST_FULL;
                end
            end
            kvt_pkg::REQ_REMOVE, kvt_pkg::REQ_GET:
            begin
                if (found_reg)
                begin
                    res_status = kvt_pkg::ST_OK;
                    res_value  = hit_val_reg;
                    res_idx    = hit_idx_reg;
                    if (req_reg == kvt_pkg::REQ_REMOVE)
                    begin
                        // free the slot, key and value words stay
                        res_we          = 1'b1;
                        res_wdata.valid = 1'b0;
                        res_wdata.key   = key_reg;
                        res_wdata.value = hit_val_reg;
                        res_count       = count_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                res_status = kvt_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    assign res_idx_ext   = 32'(res_idx);
    assign res_count_ext = 32'(res_count);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        req_next        = req_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        hit_idx_next    = hit_idx_reg;
        hit_val_next    = hit_val_reg;
        free_idx_next   = free_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_slot_next   = out_slot_reg;
        out_occ_next    = out_occ_reg;
        mem_we          = 1'b0;
        mem_waddr       = cnt_reg[IDX_W-1:0];
        mem_wdata       = '0;
        s_tready        = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (in_accept)
                begin
                    req_next        = s_tuser;
                    key_next        = s_tdata[31:0];
                    val_next        = s_tdata[63:32];
                    cnt_next        = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmp_idx_next = cnt_reg[IDX_W-1:0];
                cnt_next     = cnt_reg + CNT_W'(1);
                // read data lags the address through the registered read port
                if (cnt_reg != '0)
                begin
                    if (rd_data_reg.valid && rd_data_reg.key == key_reg && !found_reg)
                    begin
                        found_next   = 1'b1;
                        hit_idx_next = cmp_idx_reg;
                        hit_val_next = rd_data_reg.value;
                    end
                    if (!rd_data_reg.valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = cmp_idx_reg;
                    end
                end
                if (cnt_reg == CNT_W'(NUM_SLOTS))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    mem_we          = res_we;
                    mem_waddr       = res_idx;
                    mem_wdata       = res_wdata;
                    count_next      = res_count;
                    out_status_next = res_status;
                    out_value_next  = res_value;
                    out_slot_next   = res_idx_ext[kvt_pkg::SLOT_W-1:0];
                    out_occ_next    = res_count_ext[kvt_pkg::OCC_W-1:0];
                    m_tvalid_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cnt_reg        <= '0;
            count_reg      <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            count_reg      <= count_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        hit_idx_reg    <= hit_idx_next;
        hit_val_reg    <= hit_val_next;
        free_idx_reg   <= free_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_slot_reg   <= out_slot_next;
        out_occ_reg    <= out_occ_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'b0, out_occ_reg, out_slot_reg, out_value_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(NUM_SLOTS))
        else $error("occupied count exceeds slot count");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_tready && (state_reg == S_SCAN))
        else $error("request accepted while another is in flight");

    a_count_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        !out_load |=> $stable(count_reg))
        else $error("occupied count changed without a result");

endmodule

`default_nettype wire
